// ----- rtl/rbpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rbpn_pkg
// Types, widths, register map and tables shared by the raw Bayer pixel
// normalizer and its divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpn_pkg;

	// sample width, raw counts are masked down to this many bits
	localparam int SAMPLE_BITS = 16;
	localparam logic [15:0] SAMPLE_MASK = 16'((1 << SAMPLE_BITS) - 1);

	// configuration map
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_WHITE     = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_BLACK_EE  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_BLACK_EO  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_BLACK_OE  = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_BLACK_OO  = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_CFA       = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_RES_EN    = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_GAIN_EN   = REG_IDX_W'(7);

	// arithmetic widths, levels in 1/16 count units
	localparam int LVL_W  = 23;           // signed black, numerator, denominator
	localparam int D_W    = 21;           // clamped denominator, 16 .. 1114096
	localparam int MAG_W  = 21;           // numerator magnitude
	localparam int GAIN_W = 16;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int NUM_W  = PROD_W + 4;   // times 16
	localparam int Q_W    = 24;           // quotient bits kept
	localparam int DIV_BITS = Q_W;        // one quotient bit per divider stage
	localparam int HI_W   = NUM_W - Q_W;  // numerator bits above the quotient range

	// input beat to first divider stage, then divider, then output register
	localparam int PIPE_LAT = 4 + DIV_BITS + 1;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(4096);
	localparam logic [LVL_W-1:0]  D_MIN    = LVL_W'(16);
	localparam logic [Q_W-1:0]    SIG_MAX  = 24'h7FFFFF;
	localparam logic [Q_W-1:0]    SIG_MIN  = 24'h800000;

	// colors
	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;

	// indexed by cfa pattern then phase
	localparam logic [1:0] COLOR_LUT [4][4] = '{
		'{COLOR_BLUE,  COLOR_GREEN, COLOR_GREEN, COLOR_RED},
		'{COLOR_RED,   COLOR_GREEN, COLOR_GREEN, COLOR_BLUE},
		'{COLOR_GREEN, COLOR_RED,   COLOR_BLUE,  COLOR_GREEN},
		'{COLOR_GREEN, COLOR_BLUE,  COLOR_RED,   COLOR_GREEN}
	};

	typedef struct packed {
		logic [15:0]        raw_sample;
		logic               row_odd;
		logic               col_odd;
		logic signed [15:0] row_bias;
		logic signed [15:0] col_bias;
		logic [15:0]        pixel_gain;
	} rbpn_in_t;

	typedef struct packed {
		logic signed [23:0] normalized_signal;
		logic [1:0]         channel_color;
		logic               high_clipped;
		logic [15:0]        clip_lower_bound;
	} rbpn_out_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [1:0]        color;
		logic              clip;
		logic [GAIN_W-1:0] gain;
		logic              neg;
		logic              ovf;
	} rbpn_side_t;

endpackage

`default_nettype wire

// ----- rtl/rbpn_div.sv -----
// ----------------------------------------------------------------------------
// rbpn_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpn_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [rbpn_pkg::D_W-1:0]     in_d,
	input  wire logic [rbpn_pkg::D_W-1:0]     in_rem,
	input  wire logic [rbpn_pkg::Q_W-1:0]     in_low,
	input  wire rbpn_pkg::rbpn_side_t         in_side,
	output logic                              out_valid,
	output logic [rbpn_pkg::Q_W-1:0]          out_quo,
	output rbpn_pkg::rbpn_side_t              out_side
);
	import rbpn_pkg::*;

	logic             valid_s [1:DIV_BITS];
	logic [D_W-1:0]   d_s     [1:DIV_BITS];
	logic [D_W-1:0]   rem_s   [1:DIV_BITS];
	logic [Q_W-1:0]   low_s   [1:DIV_BITS];
	logic [Q_W-1:0]   quo_s   [1:DIV_BITS];
	rbpn_side_t       side_s  [1:DIV_BITS];

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
		logic           cur_valid;
		logic [D_W-1:0] cur_d;
		logic [D_W-1:0] cur_rem;
		logic [Q_W-1:0] cur_low;
		logic [Q_W-1:0] cur_quo;
		rbpn_side_t     cur_side;
		logic [D_W:0]   r_sh;
		logic [D_W:0]   r_sub;
		logic           ge;

		if (k == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_d     = in_d;
			assign cur_rem   = in_rem;
			assign cur_low   = in_low;
			assign cur_quo   = '0;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[k];
			assign cur_d     = d_s[k];
			assign cur_rem   = rem_s[k];
			assign cur_low   = low_s[k];
			assign cur_quo   = quo_s[k];
			assign cur_side  = side_s[k];
		end

		// bring down the next numerator bit and try one subtract
		assign r_sh  = {cur_rem, cur_low[Q_W-1]};
		assign r_sub = r_sh - {1'b0, cur_d};
		assign ge    = (r_sh >= {1'b0, cur_d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			d_s[k+1]    <= cur_d;
			rem_s[k+1]  <= ge ? r_sub[D_W-1:0] : r_sh[D_W-1:0];
			low_s[k+1]  <= {cur_low[Q_W-2:0], 1'b0};
			quo_s[k+1]  <= {cur_quo[Q_W-2:0], ge};
			side_s[k+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[DIV_BITS];
	assign out_quo   = quo_s[DIV_BITS];
	assign out_side  = side_s[DIV_BITS];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##DIV_BITS out_valid)
		else $error("divider beat lost in pipeline");

	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_side.ovf) |-> (rem_s[DIV_BITS] < d_s[DIV_BITS]))
		else $error("final remainder not below divisor");

endmodule

`default_nettype wire

// ----- rtl/raw_bayer_pixel_normalizer.sv -----
// ----------------------------------------------------------------------------
// raw_bayer_pixel_normalizer
// Black and white level normalization of raw Bayer samples with optional
// residual row/column black and per-pixel gain, output as signed Q8.16.
// ----------------------------------------------------------------------------
//
//   channel   signals                                 handshake
//   input     item (rbpn_in_t)                        start, busy
//   result    result (rbpn_out_t)                     result_valid strobe
//   config    psel penable pwrite paddr pwdata        pready, prdata
//
// One sample per clock is accepted; busy stays low. Every result appears
// after its input beat has passed four front stages (black, difference,
// multiply, range check), 24 divider stages giving one quotient bit each,
// and the output register. The divider stage count sets the latency.
// Reset clears all valid bits and loads the register defaults.
// The result side cannot stall, so the pipeline advances every cycle.
//
`default_nettype none

module raw_bayer_pixel_normalizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rbpn_pkg::rbpn_in_t            item,
	output logic                               result_valid,
	output rbpn_pkg::rbpn_out_t                result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rbpn_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import rbpn_pkg::*;

	// configuration registers
	logic [15:0] white_q;
	logic [15:0] black_ee_q;
	logic [15:0] black_eo_q;
	logic [15:0] black_oe_q;
	logic [15:0] black_oo_q;
	logic [1:0]  cfa_q;
	logic        res_en_q;
	logic        gain_en_q;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_idx;
	logic [REG_IDX_W-1:0] rd_idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = paddr[ADDR_W-1:2];
	assign rd_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q    <= 16'hFFFF;
			black_ee_q <= '0;
			black_eo_q <= '0;
			black_oe_q <= '0;
			black_oo_q <= '0;
			cfa_q      <= '0;
			res_en_q   <= 1'b0;
			gain_en_q  <= 1'b0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_WHITE:    white_q    <= pwdata[15:0];
				REG_BLACK_EE: black_ee_q <= pwdata[15:0];
				REG_BLACK_EO: black_eo_q <= pwdata[15:0];
				REG_BLACK_OE: black_oe_q <= pwdata[15:0];
				REG_BLACK_OO: black_oo_q <= pwdata[15:0];
				REG_CFA:      cfa_q      <= pwdata[1:0];
				REG_RES_EN:   res_en_q   <= pwdata[0];
				REG_GAIN_EN:  gain_en_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			REG_WHITE:    prdata = {16'b0, white_q};
			REG_BLACK_EE: prdata = {16'b0, black_ee_q};
			REG_BLACK_EO: prdata = {16'b0, black_eo_q};
			REG_BLACK_OE: prdata = {16'b0, black_oe_q};
			REG_BLACK_OO: prdata = {16'b0, black_oo_q};
			REG_CFA:      prdata = {30'b0, cfa_q};
			REG_RES_EN:   prdata = {31'b0, res_en_q};
			REG_GAIN_EN:  prdata = {31'b0, gain_en_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- stage 1: black level, gain, color, clip
	logic [1:0]              phase;
	logic [15:0]             black_sel;
	logic [15:0]             raw_m;
	logic [15:0]             white_m;
	logic [15:0]             black_m;
	logic signed [16:0]      bias_sum;
	logic signed [LVL_W-1:0] bias_ext;
	logic signed [LVL_W-1:0] b16;
	logic [GAIN_W-1:0]       gain;

	assign phase = {item.row_odd, item.col_odd};

	always_comb begin
		case (phase)
			2'd0:    black_sel = black_ee_q;
			2'd1:    black_sel = black_eo_q;
			2'd2:    black_sel = black_oe_q;
			default: black_sel = black_oo_q;
		endcase
	end

	assign raw_m    = item.raw_sample & SAMPLE_MASK;
	assign white_m  = white_q & SAMPLE_MASK;
	assign black_m  = black_sel & SAMPLE_MASK;
	assign bias_sum = 17'(item.row_bias) + 17'(item.col_bias);
	assign bias_ext = res_en_q ? LVL_W'(bias_sum) : '0;
	assign b16      = $signed({3'b0, black_m, 4'b0}) + bias_ext;
	assign gain     = gain_en_q ? item.pixel_gain : GAIN_ONE;

	logic                    v_s1;
	logic [19:0]             raw16_s1;
	logic [19:0]             white16_s1;
	logic signed [LVL_W-1:0] b16_s1;
	rbpn_side_t              side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		raw16_s1   <= {raw_m, 4'b0};
		white16_s1 <= {white_m, 4'b0};
		b16_s1     <= b16;
		side_s1    <= '{color: COLOR_LUT[cfa_q][phase], clip: (raw_m >= white_m),
			gain: gain, neg: 1'b0, ovf: 1'b0};
	end

	// ---------------- stage 2: numerator magnitude and sign, clamped denominator
	logic signed [LVL_W-1:0] diff_p;
	logic signed [LVL_W-1:0] diff_n;
	logic signed [LVL_W-1:0] dd;

	assign diff_p = $signed({3'b0, raw16_s1}) - b16_s1;
	assign diff_n = b16_s1 - $signed({3'b0, raw16_s1});
	assign dd     = $signed({3'b0, white16_s1}) - b16_s1;

	logic             v_s2;
	logic [MAG_W-1:0] nmag_s2;
	logic [D_W-1:0]   d_s2;
	rbpn_side_t       side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s2 <= diff_p[LVL_W-1] ? diff_n[MAG_W-1:0] : diff_p[MAG_W-1:0];
		// black at or above white: one count
		d_s2    <= (dd < $signed(D_MIN)) ? D_MIN[D_W-1:0] : dd[D_W-1:0];
		side_s2 <= '{color: side_s1.color, clip: side_s1.clip, gain: side_s1.gain,
			neg: diff_p[LVL_W-1], ovf: side_s1.ovf};
	end

	// ---------------- stage 3: gain multiply
	logic              v_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [D_W-1:0]    d_s3;
	rbpn_side_t        side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= {{GAIN_W{1'b0}}, nmag_s2} * {{MAG_W{1'b0}}, side_s2.gain};
		d_s3    <= d_s2;
		side_s3 <= side_s2;
	end

	// ---------------- stage 4: quotient range check, divider operands
	logic [NUM_W-1:0] num;
	logic [HI_W-1:0]  num_hi;

	assign num    = {prod_s3, 4'b0};
	assign num_hi = num[NUM_W-1:Q_W];

	logic           v_s4;
	logic [D_W-1:0] d_s4;
	logic [D_W-1:0] rem_s4;
	logic [Q_W-1:0] low_s4;
	rbpn_side_t     side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		d_s4    <= d_s3;
		rem_s4  <= D_W'(num_hi);
		low_s4  <= num[Q_W-1:0];
		// quotient would not fit in Q_W bits
		side_s4 <= '{color: side_s3.color, clip: side_s3.clip, gain: side_s3.gain,
			neg: side_s3.neg, ovf: ({{(D_W-HI_W){1'b0}}, num_hi} >= d_s3)};
	end

	// ---------------- divider
	logic           div_valid;
	logic [Q_W-1:0] div_quo;
	rbpn_side_t     div_side;

	rbpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_d     (d_s4),
		.in_rem   (rem_s4),
		.in_low   (low_s4),
		.in_side  (side_s4),
		.out_valid(div_valid),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	// ---------------- output: sign and saturation
	logic [Q_W-1:0] sig;

	always_comb begin
		if (!div_side.neg) begin
			sig = (div_side.ovf || div_quo[Q_W-1]) ? SIG_MAX : div_quo;
		end else begin
			sig = (div_side.ovf || (div_quo > SIG_MIN)) ? SIG_MIN : (Q_W'(0) - div_quo);
		end
	end

	logic      result_valid_q;
	rbpn_out_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= '{normalized_signal: $signed(sig), channel_color: div_side.color,
			high_clipped: div_side.clip, clip_lower_bound: div_side.gain};
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_one_result_per_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT result_valid)
		else $error("input beat produced no result");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid && div_side.ovf) |=> (result_valid &&
		(result.normalized_signal == $signed(SIG_MAX) ||
		 result.normalized_signal == $signed(SIG_MIN))))
		else $error("out-of-range quotient not saturated");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for raw_bayer_pixel_normalizer. Pixel beats go out from
// a queue under random gaps, each accepted beat is run through a local
// black/white level model, and every result strobe is compared field by field
// with the oldest predicted pixel. Levels, CFA pattern and enables are set
// over APB while the pipeline is drained, across several settings.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rbpn_pkg::*;

	localparam int LAT = PIPE_LAT;

	// color per cfa pattern and phase
	localparam logic [1:0] CFA_COLOR [4][4] = '{
		'{COLOR_BLUE,  COLOR_GREEN, COLOR_GREEN, COLOR_RED},
		'{COLOR_RED,   COLOR_GREEN, COLOR_GREEN, COLOR_BLUE},
		'{COLOR_GREEN, COLOR_RED,   COLOR_BLUE,  COLOR_GREEN},
		'{COLOR_GREEN, COLOR_BLUE,  COLOR_RED,   COLOR_GREEN}
	};

	typedef struct {
		logic [15:0] white;
		logic [15:0] black [4];
		logic [1:0]  cfa;
		logic        res_en;
		logic        gain_en;
	} level_cfg_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	rbpn_in_t            item = '0;
	logic                result_valid;
	rbpn_out_t           result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	level_cfg_t  level_cfg;
	rbpn_in_t    pixel_queue [$];
	rbpn_out_t   expected_px [$];
	int          n_issued = 0;
	int          n_accepted = 0;
	int          mismatches = 0;
	int          gap_left = 0;
	int          burst_left = 0;

	raw_bayer_pixel_normalizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// (raw - black) / max(white - black, 1) * gain, levels in 1/16 counts
	function automatic rbpn_out_t normalize_pixel(rbpn_in_t px, level_cfg_t c);
		rbpn_out_t   r;
		logic [1:0]  phase;
		logic [15:0] raw, white, black, gain;
		longint      blk16, den16, num16, q;
		phase = {px.row_odd, px.col_odd};
		raw   = px.raw_sample & SAMPLE_MASK;
		white = c.white & SAMPLE_MASK;
		black = c.black[phase] & SAMPLE_MASK;
		blk16 = longint'(black) * 16;
		if (c.res_en)
			blk16 += longint'(px.row_bias) + longint'(px.col_bias);
		den16 = longint'(white) * 16 - blk16;
		if (den16 < 16)
			den16 = 16;
		num16 = longint'(raw) * 16 - blk16;
		gain  = c.gain_en ? px.pixel_gain : 16'd4096;
		q = (num16 * longint'(gain) * 16) / den16;
		if (q > 8388607)
			q = 8388607;
		if (q < -8388608)
			q = -8388608;
		r.normalized_signal = q[23:0];
		r.channel_color     = CFA_COLOR[c.cfa][phase];
		r.high_clipped      = (raw >= white);
		r.clip_lower_bound  = gain;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 58)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// driver: one beat per accepted start, gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				expected_px = {expected_px, normalize_pixel(item, level_cfg)};
				n_accepted++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				item     <= pixel_queue.pop_front();
				start    <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: each strobe is one result beat
	always @(posedge clk) begin
		rbpn_out_t want;
		if (arst_n && result_valid) begin
			if (expected_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %h", result);
			end else begin
				want = expected_px.pop_front();
				if (result.normalized_signal !== want.normalized_signal
						|| result.channel_color !== want.channel_color
						|| result.high_clipped !== want.high_clipped
						|| result.clip_lower_bound !== want.clip_lower_bound) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: signal %0d/%0d color %0d/%0d clip %0d/%0d gain %h/%h (exp/act)",
							$realtime, want.normalized_signal, result.normalized_signal,
							want.channel_color, result.channel_color,
							want.high_clipped, result.high_clipped,
							want.clip_lower_bound, result.clip_lower_bound);
				end
			end
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_levels(level_cfg_t c);
		write_reg(REG_WHITE, 32'(c.white));
		write_reg(REG_BLACK_EE, 32'(c.black[0]));
		write_reg(REG_BLACK_EO, 32'(c.black[1]));
		write_reg(REG_BLACK_OE, 32'(c.black[2]));
		write_reg(REG_BLACK_OO, 32'(c.black[3]));
		write_reg(REG_CFA, 32'(c.cfa));
		write_reg(REG_RES_EN, 32'(c.res_en));
		write_reg(REG_GAIN_EN, 32'(c.gain_en));
		level_cfg = c;
	endtask

	task automatic send(rbpn_in_t px);
		pixel_queue = {pixel_queue, px};
		n_issued++;
	endtask

	// wait until every beat is out and every result is back
	task automatic drain();
		int waited;
		while (n_accepted != n_issued)
			@(posedge clk);
		waited = 0;
		while (expected_px.size() != 0 && waited < 4 * LAT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_px.size() != 0) begin
			mismatches += expected_px.size();
			$display("%0d expected results never arrived", expected_px.size());
			expected_px.delete();
		end
		repeat (LAT + 2) @(posedge clk);
	endtask

	function automatic rbpn_in_t pixel(logic [15:0] raw, logic ro, logic co,
			logic [15:0] rb, logic [15:0] cb, logic [15:0] g);
		rbpn_in_t p;
		p.raw_sample = raw;
		p.row_odd    = ro;
		p.col_odd    = co;
		p.row_bias   = rb;
		p.col_bias   = cb;
		p.pixel_gain = g;
		return p;
	endfunction

	function automatic logic [15:0] rand_bias();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom);
		if (r < 8)
			return 16'($urandom_range(0, 512) - 256);
		return r[0] ? 16'h8000 : 16'h7fff;
	endfunction

	// samples often land near black and white where the math is interesting
	function automatic rbpn_in_t rand_pixel(level_cfg_t c);
		rbpn_in_t p;
		int r;
		p.row_odd  = 1'($urandom);
		p.col_odd  = 1'($urandom);
		r = $urandom_range(0, 9);
		case (r)
			0: p.raw_sample = 16'h0000;
			1: p.raw_sample = 16'hffff;
			2, 3: p.raw_sample = 16'(int'(c.black[{p.row_odd, p.col_odd}])
				+ $urandom_range(0, 64) - 32);
			4, 5: p.raw_sample = 16'(int'(c.white) + $urandom_range(0, 64) - 32);
			default: p.raw_sample = 16'($urandom);
		endcase
		p.row_bias = rand_bias();
		p.col_bias = rand_bias();
		r = $urandom_range(0, 9);
		if (r < 6)
			p.pixel_gain = 16'($urandom);
		else if (r < 8)
			p.pixel_gain = 16'(4096 + $urandom_range(0, 512) - 256);
		else
			p.pixel_gain = r[0] ? 16'hffff : 16'h0000;
		return p;
	endfunction

	function automatic level_cfg_t rand_levels();
		level_cfg_t c;
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			c.white = 16'($urandom);
		else if (r < 3)
			c.white = r[0] ? 16'hffff : 16'h0000;
		else if (r < 5)
			c.white = 16'($urandom_range(16, 400));
		else
			c.white = 16'($urandom_range(1000, 65535));
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 9) < 8)
				c.black[i] = 16'($urandom_range(0, c.white / 8));
			else
				c.black[i] = 16'($urandom);
		end
		c.cfa     = 2'($urandom);
		c.res_en  = 1'($urandom);
		c.gain_en = 1'($urandom);
		return c;
	endfunction

	initial begin
		level_cfg_t c;
		level_cfg.white   = 16'hffff;
		level_cfg.black   = '{16'd0, 16'd0, 16'd0, 16'd0};
		level_cfg.cfa     = 2'd0;
		level_cfg.res_en  = 1'b0;
		level_cfg.gain_en = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: unit gain, full range
		send(pixel(16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'hffff));
		send(pixel(16'hffff, 1'b1, 1'b1, 16'h7fff, 16'h8000, 16'h1234));
		send(pixel(16'h8000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
		drain();

		// moderate levels, both enables on, every phase
		c.white = 16'd4000;
		c.black = '{16'd64, 16'd100, 16'd200, 16'd256};
		c.cfa = 2'd1;
		c.res_en = 1'b1;
		c.gain_en = 1'b1;
		load_levels(c);
		send(pixel(16'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'd4096));
		send(pixel(16'd64, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'd4096));
		send(pixel(16'd4000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'd4096));
		send(pixel(16'd3999, 1'b1, 1'b0, 16'h0010, 16'hfff0, 16'hffff));
		send(pixel(16'hffff, 1'b1, 1'b1, 16'h7fff, 16'h7fff, 16'hffff));
		send(pixel(16'd1000, 1'b1, 1'b1, 16'h8000, 16'h8000, 16'hffff));
		send(pixel(16'd1000, 1'b0, 1'b1, 16'h8000, 16'h7fff, 16'h0000));
		send(pixel(16'd10, 1'b1, 1'b0, 16'h0100, 16'h0200, 16'd8192));
		drain();

		// black at, above or just below white, clamped span
		c.white = 16'd100;
		c.black = '{16'd100, 16'hffff, 16'd150, 16'd99};
		c.cfa = 2'd2;
		c.res_en = 1'b1;
		c.gain_en = 1'b1;
		load_levels(c);
		for (int i = 0; i < 4; i++)
			send(pixel(16'(i * 40), i[1], i[0], 16'h0000, 16'h0008, 16'd4096));
		send(pixel(16'hffff, 1'b0, 1'b1, 16'h8000, 16'h8000, 16'hffff));
		drain();

		// gain disabled, pixel gain must be ignored
		c.white = 16'h0000;
		c.black = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
		c.cfa = 2'd3;
		c.res_en = 1'b0;
		c.gain_en = 1'b0;
		load_levels(c);
		for (int i = 0; i < 4; i++)
			send(pixel(16'hffff - 16'(i), i[1], i[0], 16'h7fff, 16'h8000, 16'hffff));
		send(pixel(16'h0000, 1'b0, 1'b0, 16'h1234, 16'h4321, 16'h0000));
		drain();

		// random part, each phase under a fresh level set
		for (int ph = 0; ph < 14; ph++) begin
			c = rand_levels();
			if (ph == 0) begin
				c.white = 16'h0000;
				c.black = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
				c.res_en = 1'b1;
				c.gain_en = 1'b1;
			end else if (ph == 1) begin
				c.white = 16'hffff;
				c.black = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
				c.res_en = 1'b0;
				c.gain_en = 1'b0;
			end
			load_levels(c);
			for (int i = 0; i < 100; i++)
				send(rand_pixel(c));
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
